@@ hdl/pixel_gamma_brightness_contrast_top_defines.svh @@
// Assertion helpers for the checker of this block.
`ifndef PIXEL_GAMMA_BRIGHTNESS_CONTRAST_TOP_DEFINES_SVH
`define PIXEL_GAMMA_BRIGHTNESS_CONTRAST_TOP_DEFINES_SVH

// Checked only outside reset.
`define PGBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define PGBC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ hdl/pgbc_pkg.sv @@
`timescale 1ns / 1ps

package pgbc_pkg;

    localparam int PIX_W     = 8;
    localparam int LUT_DEPTH = 1 << PIX_W;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 6 * PIX_W;
    localparam int M_TDATA_W = 4 * PIX_W;

    localparam logic [PIX_W-1:0] MID_GREY = 8'd128;
    localparam logic [PIX_W-1:0] MAX_PIX  = 8'd255;

    localparam logic             RST_ENABLE     = 1'b1;
    localparam logic [PIX_W-1:0] RST_BRIGHTNESS = 8'd255;
    localparam logic [PIX_W-1:0] RST_CONTRAST   = 8'd128;

    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_TABLE = 1'b1
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE     = 2'd0,
        CFG_BRIGHTNESS = 2'd1,
        CFG_CONTRAST   = 2'd2
    } t_cfg_idx;

    // Per-stage load enables and the gamma table write strobe.
    typedef struct packed {
        logic wr;
        logic ld2;
        logic ld3;
        logic ld4;
        logic ld5;
        logic ld6;
    } t_lane_ctl;

endpackage

@@ hdl/pixel_gamma_brightness_contrast_top.sv @@
`timescale 1ns / 1ps

// Per-pixel gamma, brightness and contrast correction on a stream, one beat per clock
// when nothing stalls; each stage holds its own valid bit, so bubbles close up under
// back-pressure. A beat with tuser set writes one gamma table entry and yields no
// output beat; the gamma table is held once per colour channel (one write and one
// registered read port each), and an entry must be written before any pixel reads it.
// Alpha is carried through untouched, and with correction disabled R, G and B pass
// unchanged. Registers must be written only while no pixel is in flight; the block
// itself does not enforce it.

module pixel_gamma_brightness_contrast_top
    import pgbc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // red, green, blue, alpha, table_index, table_value
    input  logic                 i_s_tuser,  // mode

    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,  // red, green, blue, alpha

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PIX_W-1:0]     i_cfg_data
);

    logic             r_enable;
    logic [PIX_W-1:0] r_brightness;
    logic [PIX_W-1:0] r_contrast;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic ld1, ld2, ld3, ld4, ld5, ld6;

    t_mode                r_mode1;
    logic [S_TDATA_W-1:0] r_data1;
    logic [PIX_W-1:0]     r_alpha2, r_alpha3, r_alpha4, r_alpha5, r_alpha6;

    t_lane_ctl        lane_ctl;
    logic [PIX_W-1:0] red_out, green_out, blue_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= RST_ENABLE;
            r_brightness <= RST_BRIGHTNESS;
            r_contrast   <= RST_CONTRAST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLE:     r_enable     <= i_cfg_data[0];
                CFG_BRIGHTNESS: r_brightness <= i_cfg_data;
                CFG_CONTRAST:   r_contrast   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign ld6 = !r_v6 || i_m_tready;
    assign ld5 = !r_v5 || ld6;
    assign ld4 = !r_v4 || ld5;
    assign ld3 = !r_v3 || ld4;
    assign ld2 = !r_v2 || ld3;
    assign ld1 = !r_v1 || ld2;

    assign o_s_tready = ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (ld1) r_v1 <= i_s_tvalid;
            if (ld2) r_v2 <= r_v1 && (r_mode1 == MODE_PIXEL);
            if (ld3) r_v3 <= r_v2;
            if (ld4) r_v4 <= r_v3;
            if (ld5) r_v5 <= r_v4;
            if (ld6) r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_mode1 <= t_mode'(i_s_tuser);
            r_data1 <= i_s_tdata;
        end
        if (ld2) r_alpha2 <= r_data1[31:24];
        if (ld3) r_alpha3 <= r_alpha2;
        if (ld4) r_alpha4 <= r_alpha3;
        if (ld5) r_alpha5 <= r_alpha4;
        if (ld6) r_alpha6 <= r_alpha5;
    end

    // table write lands as the beat leaves stage 1, ahead of any later pixel's read
    assign lane_ctl.wr  = ld2 && r_v1 && (r_mode1 == MODE_TABLE);
    assign lane_ctl.ld2 = ld2;
    assign lane_ctl.ld3 = ld3;
    assign lane_ctl.ld4 = ld4;
    assign lane_ctl.ld5 = ld5;
    assign lane_ctl.ld6 = ld6;

    pgbc_lane u_lane_red (
        .i_clk        (i_clk),
        .i_ctl        (lane_ctl),
        .i_wr_idx     (r_data1[39:32]),
        .i_wr_val     (r_data1[47:40]),
        .i_comp       (r_data1[7:0]),
        .i_enable     (r_enable),
        .i_brightness (r_brightness),
        .i_contrast   (r_contrast),
        .o_comp       (red_out)
    );

    pgbc_lane u_lane_green (
        .i_clk        (i_clk),
        .i_ctl        (lane_ctl),
        .i_wr_idx     (r_data1[39:32]),
        .i_wr_val     (r_data1[47:40]),
        .i_comp       (r_data1[15:8]),
        .i_enable     (r_enable),
        .i_brightness (r_brightness),
        .i_contrast   (r_contrast),
        .o_comp       (green_out)
    );

    pgbc_lane u_lane_blue (
        .i_clk        (i_clk),
        .i_ctl        (lane_ctl),
        .i_wr_idx     (r_data1[39:32]),
        .i_wr_val     (r_data1[47:40]),
        .i_comp       (r_data1[23:16]),
        .i_enable     (r_enable),
        .i_brightness (r_brightness),
        .i_contrast   (r_contrast),
        .o_comp       (blue_out)
    );

    assign o_m_tvalid = r_v6;
    assign o_m_tdata  = {r_alpha6, blue_out, green_out, red_out};

endmodule

@@ hdl/pgbc_lane.sv @@
`timescale 1ns / 1ps

module pgbc_lane
    import pgbc_pkg::*;
(
    input  logic             i_clk,
    input  t_lane_ctl        i_ctl,
    input  logic [PIX_W-1:0] i_wr_idx,
    input  logic [PIX_W-1:0] i_wr_val,
    input  logic [PIX_W-1:0] i_comp,
    input  logic             i_enable,
    input  logic [PIX_W-1:0] i_brightness,
    input  logic [PIX_W-1:0] i_contrast,
    output logic [PIX_W-1:0] o_comp
);

    logic [PIX_W-1:0] r_gamma [LUT_DEPTH];

    logic [PIX_W-1:0]   r_gam2;
    logic [PIX_W-1:0]   r_raw2;
    logic [2*PIX_W-1:0] r_prod3;
    logic [PIX_W-1:0]   r_raw3;
    logic [PIX_W-1:0]   r_bri4;
    logic [PIX_W-1:0]   r_raw4;
    logic signed [16:0] r_cp5;
    logic [PIX_W-1:0]   r_raw5;
    logic [PIX_W-1:0]   r_comp6;

    logic [2*PIX_W-1:0] div_sum;
    logic signed [8:0]  c_diff;
    logic signed [8:0]  c_gain;
    logic signed [17:0] c_prod;
    logic signed [10:0] c_res;
    logic [PIX_W-1:0]   c_clamp;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_gamma[i_wr_idx] <= i_wr_val;
        end
        if (i_ctl.ld2) begin
            r_gam2 <= r_gamma[i_comp];
        end
    end

    // floor(p / 255), exact for every p up to 255 * 255, the largest product
    assign div_sum = r_prod3 + {8'd0, r_prod3[15:8]} + 16'd1;

    assign c_diff = $signed({1'b0, r_bri4}) - $signed({1'b0, MID_GREY});
    assign c_gain = $signed({1'b0, i_contrast});
    assign c_prod = c_diff * c_gain;

    // arithmetic shift by 7 is the floor of the divide by 128
    assign c_res = $signed({r_cp5[16], r_cp5[16:7]}) + $signed({3'd0, MID_GREY});

    always_comb begin
        if (c_res[10]) begin
            c_clamp = '0;
        end else if (c_res[9:8] != 2'd0) begin
            c_clamp = MAX_PIX;
        end else begin
            c_clamp = c_res[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_raw2 <= i_comp;
        end
        if (i_ctl.ld3) begin
            r_prod3 <= r_gam2 * i_brightness;
            r_raw3  <= r_raw2;
        end
        if (i_ctl.ld4) begin
            r_bri4 <= div_sum[15:8];
            r_raw4 <= r_raw3;
        end
        if (i_ctl.ld5) begin
            r_cp5  <= c_prod[16:0];
            r_raw5 <= r_raw4;
        end
        if (i_ctl.ld6) begin
            r_comp6 <= i_enable ? c_clamp : r_raw5;
        end
    end

    assign o_comp = r_comp6;

endmodule

@@ hdl/pgbc_checker.sv @@
`timescale 1ns / 1ps
`include "pixel_gamma_brightness_contrast_top_defines.svh"

module pgbc_checker
    import pgbc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata
);

    `PGBC_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_m_tvalid, "output beat right after reset")

    // an empty output stage lets the whole pipe move
    `PGBC_ASSERT(a_ready_when_drained, !o_m_tvalid |-> o_s_tready, "input stalled, output empty")

    `PGBC_ASSERT(a_valid_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "output beat dropped")

    `PGBC_ASSERT(a_data_hold, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata), "stalled data moved")

endmodule

bind pixel_gamma_brightness_contrast_top pgbc_checker u_pgbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import pgbc_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] alpha;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_rgba;

    typedef struct packed {
        logic [PIX_W-1:0] tbl_value;
        logic [PIX_W-1:0] tbl_index;
        t_rgba            px;
    } t_in_word;

    class t_color_correct_model;
        logic [PIX_W-1:0] gamma_lut [LUT_DEPTH];
        bit    enable;
        int    bright;
        int    contrast;
        t_rgba pending [$];
        int    n_pixels;
        int    n_writes;
        int    n_errors;

        function new();
            foreach (gamma_lut[i]) gamma_lut[i] = '0;
            enable   = RST_ENABLE;
            bright   = int'(RST_BRIGHTNESS);
            contrast = int'(RST_CONTRAST);
        endfunction

        function void set_reg(t_cfg_idx idx, logic [PIX_W-1:0] data);
            case (idx)
                CFG_ENABLE:     enable   = data[0];
                CFG_BRIGHTNESS: bright   = int'(data);
                CFG_CONTRAST:   contrast = int'(data);
                default: ;
            endcase
        endfunction

        // gamma lookup, brightness scale, contrast around mid-grey with clamp
        function logic [PIX_W-1:0] grade(logic [PIX_W-1:0] comp);
            int lvl;
            int prod;
            int res;
            lvl  = int'(gamma_lut[comp]);
            lvl  = (lvl * bright) / 255;
            prod = (lvl - 128) * contrast;
            res  = (prod + 32768) / 128 - 128;
            if (res < 0)
                res = 0;
            else if (res > 255)
                res = 255;
            return res[PIX_W-1:0];
        endfunction

        function void note_beat(t_mode mode, t_in_word w);
            t_rgba exp_px;
            if (mode == MODE_TABLE) begin
                gamma_lut[w.tbl_index] = w.tbl_value;
                n_writes++;
            end else begin
                exp_px = w.px;
                if (enable) begin
                    exp_px.red   = grade(w.px.red);
                    exp_px.green = grade(w.px.green);
                    exp_px.blue  = grade(w.px.blue);
                end
                pending.push_back(exp_px);
                n_pixels++;
            end
        endfunction

        function void report(string msg);
            n_errors++;
            if (n_errors <= 10)
                $display("%t ERROR %s", $realtime, msg);
        endfunction

        function void check_beat(t_rgba got);
            t_rgba exp_px;
            if (pending.size() == 0) begin
                report($sformatf("unexpected output beat r=%0d g=%0d b=%0d a=%0d",
                                 got.red, got.green, got.blue, got.alpha));
                return;
            end
            exp_px = pending.pop_front();
            if (got.red !== exp_px.red || got.green !== exp_px.green ||
                got.blue !== exp_px.blue || got.alpha !== exp_px.alpha)
                report($sformatf("exp r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                                 exp_px.red, exp_px.green, exp_px.blue, exp_px.alpha,
                                 got.red, got.green, got.blue, got.alpha));
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;
    logic                 i_s_tuser   = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [PIX_W-1:0]     i_cfg_data  = '0;

    localparam int N_PHASES   = 9;
    localparam int RAND_ITEMS = 150;
    localparam int HOLD_START = 500;
    localparam int HOLD_LEN   = 250;

    t_color_correct_model sb;
    int tx_idle_pct = 38;
    int rx_idle_pct = 60;
    int n_in        = 0;
    bit cur_en      = 1'b1;
    bit loaded [LUT_DEPTH];
    logic [PIX_W-1:0] loaded_q [$];

    always #5 i_clk = ~i_clk;

    pixel_gamma_brightness_contrast_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            sb.note_beat(t_mode'(i_s_tuser), t_in_word'(i_s_tdata));
            n_in++;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_beat(t_rgba'(o_m_tdata));
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            sb.set_reg(t_cfg_idx'(i_cfg_index), i_cfg_data);
    end

    // output side: random stalls plus one long hold-off to back the pipe up
    initial begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && n_in >= HOLD_START) begin
                held      = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("pixel_gamma_brightness_contrast_top: mismatch");
        $finish;
    end

    task automatic send_beat(t_mode mode, t_in_word w);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= w;
        do @(posedge i_clk); while (!o_s_tready);
        if (mode == MODE_TABLE && !loaded[w.tbl_index]) begin
            loaded[w.tbl_index] = 1'b1;
            loaded_q.push_back(w.tbl_index);
        end
    endtask

    task automatic send_write(logic [PIX_W-1:0] idx, logic [PIX_W-1:0] val);
        t_in_word w;
        w.px        = $urandom;
        w.tbl_index = idx;
        w.tbl_value = val;
        send_beat(MODE_TABLE, w);
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                              logic [PIX_W-1:0] b, logic [PIX_W-1:0] a);
        t_in_word w;
        w.tbl_index = PIX_W'($urandom_range(255));
        w.tbl_value = PIX_W'($urandom_range(255));
        w.px        = '{alpha: a, blue: b, green: g, red: r};
        send_beat(MODE_PIXEL, w);
    endtask

    function automatic logic [PIX_W-1:0] pick_loaded();
        return loaded_q[$urandom_range(loaded_q.size() - 1)];
    endfunction

    task automatic send_random_item();
        t_in_word w;
        w.px        = $urandom;
        w.tbl_index = PIX_W'($urandom_range(255));
        w.tbl_value = PIX_W'($urandom_range(255));
        if ($urandom_range(99) < 20) begin
            send_beat(MODE_TABLE, w);
        end else begin
            // with correction on, only read gamma entries already loaded
            if (cur_en) begin
                w.px.red   = pick_loaded();
                w.px.green = pick_loaded();
                w.px.blue  = pick_loaded();
            end
            send_beat(MODE_PIXEL, w);
        end
    endtask

    task automatic drain_pipe();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [PIX_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(bit en, logic [PIX_W-1:0] br, logic [PIX_W-1:0] ct);
        drain_pipe();
        write_reg(CFG_ENABLE, {7'd0, en});
        write_reg(CFG_BRIGHTNESS, br);
        write_reg(CFG_CONTRAST, ct);
        cur_en = en;
    endtask

    initial begin
        bit               ph_en [N_PHASES];
        logic [PIX_W-1:0] ph_br [N_PHASES];
        logic [PIX_W-1:0] ph_ct [N_PHASES];
        ph_en = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
        ph_br = '{8'd255, 8'd0, 8'd255, 8'd255, 8'd200, 8'd1, 8'd128, 8'd0, 8'd0};
        ph_ct = '{8'd128, 8'd255, 8'd255, 8'd0, 8'd40, 8'd1, 8'd129, 8'd0, 8'd0};
        ph_br[7] = PIX_W'($urandom_range(255));
        ph_ct[7] = PIX_W'($urandom_range(255));
        ph_br[8] = PIX_W'($urandom_range(255));
        ph_ct[8] = PIX_W'($urandom_range(255));
        foreach (loaded[i]) loaded[i] = 1'b0;
        sb = new();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 3) begin
                tx_idle_pct = 60;
                rx_idle_pct = 38;
            end else if (p == 6) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            apply_settings(ph_en[p], ph_br[p], ph_ct[p]);
            if (p == 0) begin
                send_write(8'd0, 8'd255);
                send_write(8'd255, 8'd0);
                send_write(8'd128, 8'd128);
                send_write(8'd127, 8'd200);
                send_write(8'd1, 8'd1);
                send_write(8'hAA, 8'h55);
                send_write(8'h55, 8'hAA);
                send_write(8'd64, 8'd37);
                send_pixel(8'hAA, 8'h55, 8'd64, 8'h55);
                send_pixel(8'd255, 8'd0, 8'd128, 8'd1);
            end
            send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
            send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
            send_pixel(8'd128, 8'd127, 8'd1, 8'hAA);
            repeat (RAND_ITEMS) send_random_item();
        end

        drain_pipe();
        repeat (20) @(posedge i_clk);

        $display("Ran %0d pixels and %0d gamma writes across %0d register settings,",
                 sb.n_pixels, sb.n_writes, N_PHASES);
        $display("with random stalls on both sides and a %0d-cycle output hold-off.",
                 HOLD_LEN);
        if (sb.n_errors == 0 && sb.pending.size() == 0) begin
            $display("pixel_gamma_brightness_contrast_top: match");
        end else begin
            $display("%0d errors, %0d results outstanding", sb.n_errors, sb.pending.size());
            $display("pixel_gamma_brightness_contrast_top: mismatch");
        end
        $finish;
    end

endmodule
